// File: hdl/env_sensor_compensation_macros.svh
// Assertion macros shared by the environmental sensor compensation RTL.
`ifndef ENV_SENSOR_COMPENSATION_MACROS_SVH
`define ENV_SENSOR_COMPENSATION_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define ESC_ASSERT_IMPL(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("esc assertion failed");

// Next-cycle implication, clocked on i_clk, off during reset.
`define ESC_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("esc assertion failed");

`endif

// File: hdl/esc_pkg.sv
// Types and constants for the environmental sensor compensation pipeline.
package esc_pkg;

    typedef enum logic [2:0] {
        CFG_CALIB_A    = 3'd0,
        CFG_CALIB_B    = 3'd1,
        CFG_CALIB_C    = 3'd2,
        CFG_CALIB_D    = 3'd3,
        CFG_CALIB_LAST = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
        logic [15:0] raw_humidity;
    } t_in;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic [31:0]        pressure_q24_8;
        logic               pressure_valid;
        logic [16:0]        humidity_q22_10;
    } t_out;

    typedef struct packed {
        logic signed [31:0] temp;
        logic [16:0]        hum;
    } t_side;

    typedef struct packed {
        logic [15:0]        t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic [15:0]        p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
        logic [7:0]         h1;
        logic signed [15:0] h2;
        logic [7:0]         h3;
        logic signed [11:0] h4;
        logic signed [11:0] h5;
        logic signed [7:0]  h6;
    } t_calib;

    localparam int C_DIV_BITS = 64;

    localparam logic signed [31:0] C_T_MUL        = 32'sd5;
    localparam logic signed [31:0] C_T_RND        = 32'sd128;
    localparam logic signed [32:0] C_P_TFINE_OFS  = 33'sd128000;
    localparam logic signed [63:0] C_P_BIAS       = 64'sh0000_8000_0000_0000;
    localparam logic [20:0]        C_P_RAW_FULL   = 21'd1048576;
    localparam logic signed [13:0] C_P_SCALE      = 14'sd3125;
    localparam logic signed [31:0] C_H_TFINE_OFS  = 32'sd76800;
    localparam logic signed [31:0] C_H_A_RND      = 32'sd16384;
    localparam logic signed [31:0] C_H_C_OFS      = 32'sd32768;
    localparam logic signed [31:0] C_H_B_OFS      = 32'sd2097152;
    localparam logic signed [31:0] C_H_B_RND      = 32'sd8192;
    localparam logic signed [31:0] C_H_MAX        = 32'sd419430400;

endpackage

// File: hdl/esc_calib.sv
// Calibration byte registers and coefficient decode.
module esc_calib import esc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata,
    output t_calib      o_cal
);

    logic [63:0]  r_bytes [0:3];
    logic [7:0]   r_last;
    logic [263:0] w_cb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes[0] <= '0;
            r_bytes[1] <= '0;
            r_bytes[2] <= '0;
            r_bytes[3] <= '0;
            r_last     <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CALIB_A:    r_bytes[0] <= i_cfg_wdata;
                CFG_CALIB_B:    r_bytes[1] <= i_cfg_wdata;
                CFG_CALIB_C:    r_bytes[2] <= i_cfg_wdata;
                CFG_CALIB_D:    r_bytes[3] <= i_cfg_wdata;
                CFG_CALIB_LAST: r_last     <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign w_cb = {r_last, r_bytes[3], r_bytes[2], r_bytes[1], r_bytes[0]};

    always_comb begin
        o_cal.t1 = w_cb[15:0];
        o_cal.t2 = w_cb[31:16];
        o_cal.t3 = w_cb[47:32];
        o_cal.p1 = w_cb[63:48];
        o_cal.p2 = w_cb[79:64];
        o_cal.p3 = w_cb[95:80];
        o_cal.p4 = w_cb[111:96];
        o_cal.p5 = w_cb[127:112];
        o_cal.p6 = w_cb[143:128];
        o_cal.p7 = w_cb[159:144];
        o_cal.p8 = w_cb[175:160];
        o_cal.p9 = w_cb[191:176];
        o_cal.h1 = w_cb[207:200];
        o_cal.h2 = w_cb[223:208];
        o_cal.h3 = w_cb[231:224];
        o_cal.h4 = {w_cb[239:232], w_cb[243:240]};
        o_cal.h5 = {w_cb[255:248], w_cb[247:244]};
        o_cal.h6 = w_cb[263:256];
    end

endmodule

// File: hdl/esc_front.sv
// Front pipeline: temperature, humidity and the pressure dividend and divisor.
module esc_front import esc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  t_in                i_data,
    input  t_calib             i_cal,
    output logic               o_vld,
    output logic signed [63:0] o_num,
    output logic signed [63:0] o_den,
    output t_side              o_side
);

    logic [15:1] r_vld;

    logic signed [18:0] r_x;
    logic signed [17:0] r_y;
    logic [19:0]        r_ap [1:8];
    logic [15:0]        r_ah [1:5];
    logic signed [31:0] r_px, r_sq, r_tv1, r_q, r_tf, r_t5, r_hv;
    logic signed [32:0] r_v1, r_v1d;
    logic signed [63:0] r_vv, r_v2a, r_v1b, r_v2, r_v1c, r_dp, r_num0;
    logic signed [48:0] r_v1p5, r_v1p2;
    logic signed [31:0] r_h5hv, r_hvh6, r_hvh3, r_base;
    logic signed [31:0] r_a0, r_c6, r_c3, r_bm, r_b1, r_b2, r_b, r_sq2, r_t;
    logic signed [31:0] r_a [8:11];
    logic signed [31:0] r_hm [12:14];
    logic signed [31:0] r_temp [6:15];
    logic signed [63:0] r_num [10:15];
    logic signed [63:0] r_den [10:15];
    logic [16:0]        r_hum;

    logic signed [18:0] w_x;
    logic signed [17:0] w_y;
    logic signed [34:0] w_px;
    logic signed [35:0] w_sq;
    logic signed [47:0] w_q;
    logic signed [65:0] w_vv;
    logic signed [48:0] w_v1p5, w_v1p2;
    logic signed [43:0] w_h5hv;
    logic signed [39:0] w_hvh6;
    logic signed [40:0] w_hvh3;
    logic signed [31:0] w_base;
    logic signed [79:0] w_v2a, w_v1b;
    logic signed [31:0] w_c3, w_a1;
    logic signed [63:0] w_bm;
    logic signed [63:0] w_dp0;
    logic signed [80:0] w_dp;
    logic [20:0]        w_pp;
    logic signed [77:0] w_num;
    logic signed [31:0] w_b2a, w_b3;
    logic signed [47:0] w_b2;
    logic signed [63:0] w_hm;
    logic signed [31:0] w_s;
    logic signed [63:0] w_sq2;
    logic signed [40:0] w_t;
    logic signed [31:0] w_hv, w_hc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[14:1], i_vld};
        end
    end

    assign w_x    = $signed({2'b00, i_data.raw_temperature[19:3]})
                  - $signed({2'b00, i_cal.t1, 1'b0});
    assign w_y    = $signed({2'b00, i_data.raw_temperature[19:4]})
                  - $signed({2'b00, i_cal.t1});
    assign w_px   = r_x * i_cal.t2;
    assign w_sq   = r_y * r_y;
    assign w_q    = (r_sq >>> 12) * i_cal.t3;
    assign w_vv   = r_v1 * r_v1;
    assign w_h5hv = i_cal.h5 * r_hv;
    assign w_hvh6 = r_hv * i_cal.h6;
    assign w_hvh3 = r_hv * $signed({1'b0, i_cal.h3});
    assign w_base = $signed({2'b00, r_ah[5], 14'b0}) - $signed({i_cal.h4, 20'b0});
    assign w_v2a  = r_vv * i_cal.p6;
    assign w_v1b  = r_vv * i_cal.p3;
    assign w_v1p5 = r_v1d * i_cal.p5;
    assign w_v1p2 = r_v1d * i_cal.p2;
    assign w_c3   = (r_hvh3 >>> 11) + C_H_C_OFS;
    assign w_a1   = r_a0 + C_H_A_RND;
    assign w_bm   = r_c6 * r_c3;
    assign w_dp0  = r_v1c + C_P_BIAS;
    assign w_dp   = w_dp0 * $signed({1'b0, i_cal.p1});
    assign w_pp   = C_P_RAW_FULL - {1'b0, r_ap[8]};
    assign w_num  = r_num0 * C_P_SCALE;
    assign w_b2a  = r_b1 + C_H_B_OFS;
    assign w_b2   = w_b2a * i_cal.h2;
    assign w_b3   = r_b2 + C_H_B_RND;
    assign w_hm   = r_a[11] * r_b;
    assign w_s    = r_hm[12] >>> 15;
    assign w_sq2  = w_s * w_s;
    assign w_t    = (r_sq2 >>> 7) * $signed({1'b0, i_cal.h1});
    assign w_hv   = r_hm[14] - (r_t >>> 4);

    always_comb begin
        if (w_hv < 32'sd0) begin
            w_hc = '0;
        end else if (w_hv > C_H_MAX) begin
            w_hc = C_H_MAX;
        end else begin
            w_hc = w_hv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // temperature
            r_x       <= w_x;
            r_y       <= w_y;
            r_ap[1]   <= i_data.raw_pressure;
            r_ah[1]   <= i_data.raw_humidity;
            r_px      <= w_px[31:0];
            r_sq      <= w_sq[31:0];
            r_tv1     <= r_px >>> 11;
            r_q       <= w_q[31:0];
            r_tf      <= r_tv1 + (r_q >>> 14);
            r_t5      <= r_tf * C_T_MUL + C_T_RND;
            r_v1      <= 33'(r_tf) - C_P_TFINE_OFS;
            r_hv      <= r_tf - C_H_TFINE_OFS;
            r_temp[6] <= r_t5 >>> 8;
            // pressure
            r_vv      <= w_vv[63:0];
            r_v1d     <= r_v1;
            r_v2a     <= w_v2a[63:0];
            r_v1b     <= w_v1b[63:0];
            r_v1p5    <= w_v1p5;
            r_v1p2    <= w_v1p2;
            r_v2      <= r_v2a + (64'(r_v1p5) <<< 17) + (64'(i_cal.p4) <<< 35);
            r_v1c     <= (r_v1b >>> 8) + (64'(r_v1p2) <<< 12);
            r_dp      <= w_dp[63:0];
            r_num0    <= $signed({12'b0, w_pp, 31'b0}) - r_v2;
            r_den[10] <= r_dp >>> 33;
            r_num[10] <= w_num[63:0];
            // humidity
            r_h5hv    <= w_h5hv[31:0];
            r_hvh6    <= w_hvh6[31:0];
            r_hvh3    <= w_hvh3[31:0];
            r_base    <= w_base;
            r_a0      <= r_base - r_h5hv;
            r_c6      <= r_hvh6 >>> 10;
            r_c3      <= w_c3;
            r_a[8]    <= w_a1 >>> 15;
            r_bm      <= w_bm[31:0];
            r_b1      <= r_bm >>> 10;
            r_b2      <= w_b2[31:0];
            r_b       <= w_b3 >>> 14;
            r_hm[12]  <= w_hm[31:0];
            r_sq2     <= w_sq2[31:0];
            r_t       <= w_t[31:0];
            r_hum     <= w_hc[28:12];
            for (int k = 2; k <= 8; k++) begin
                r_ap[k] <= r_ap[k-1];
            end
            for (int k = 2; k <= 5; k++) begin
                r_ah[k] <= r_ah[k-1];
            end
            for (int k = 9; k <= 11; k++) begin
                r_a[k] <= r_a[k-1];
            end
            for (int k = 13; k <= 14; k++) begin
                r_hm[k] <= r_hm[k-1];
            end
            for (int k = 7; k <= 15; k++) begin
                r_temp[k] <= r_temp[k-1];
            end
            for (int k = 11; k <= 15; k++) begin
                r_num[k] <= r_num[k-1];
                r_den[k] <= r_den[k-1];
            end
        end
    end

    assign o_vld       = r_vld[15];
    assign o_num       = r_num[15];
    assign o_den       = r_den[15];
    assign o_side.temp = r_temp[15];
    assign o_side.hum  = r_hum;

endmodule

// File: hdl/esc_div.sv
// Pipelined signed 64-bit divider, one restoring step per stage.
module esc_div import esc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic signed [63:0] i_num,
    input  logic signed [63:0] i_den,
    input  t_side              i_side,
    output logic               o_vld,
    output logic signed [63:0] o_quo,
    output logic               o_nz,
    output t_side              o_side
);

    logic [C_DIV_BITS+1:0] r_vld;
    logic [127:0]          r_z    [0:C_DIV_BITS];
    logic [63:0]           r_d    [0:C_DIV_BITS-1];
    logic                  r_neg  [0:C_DIV_BITS];
    logic                  r_nz   [0:C_DIV_BITS+1];
    t_side                 r_side [0:C_DIV_BITS+1];
    logic signed [63:0]    r_q;
    logic [127:0]          n_z    [1:C_DIV_BITS];
    logic [63:0]           w_an, w_ad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[C_DIV_BITS:0], i_vld};
        end
    end

    assign w_an = i_num[63] ? 64'(-i_num) : 64'(i_num);
    assign w_ad = i_den[63] ? 64'(-i_den) : 64'(i_den);

    always_comb begin
        logic [127:0] v_sh;
        for (int k = 1; k <= C_DIV_BITS; k++) begin
            v_sh = {r_z[k-1][126:0], 1'b0};
            if (v_sh[127:64] >= r_d[k-1]) begin
                n_z[k] = {v_sh[127:64] - r_d[k-1], v_sh[63:1], 1'b1};
            end else begin
                n_z[k] = v_sh;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z[0]    <= {64'b0, w_an};
            r_d[0]    <= w_ad;
            r_neg[0]  <= i_num[63] ^ i_den[63];
            r_nz[0]   <= (i_den != 64'sd0);
            r_side[0] <= i_side;
            for (int k = 1; k <= C_DIV_BITS; k++) begin
                r_z[k]    <= n_z[k];
                r_neg[k]  <= r_neg[k-1];
                r_nz[k]   <= r_nz[k-1];
                r_side[k] <= r_side[k-1];
            end
            for (int k = 1; k < C_DIV_BITS; k++) begin
                r_d[k] <= r_d[k-1];
            end
            r_q                  <= r_neg[C_DIV_BITS] ? -$signed(r_z[C_DIV_BITS][63:0])
                                                      : $signed(r_z[C_DIV_BITS][63:0]);
            r_nz[C_DIV_BITS+1]   <= r_nz[C_DIV_BITS];
            r_side[C_DIV_BITS+1] <= r_side[C_DIV_BITS];
        end
    end

    assign o_vld  = r_vld[C_DIV_BITS+1];
    assign o_quo  = r_q;
    assign o_nz   = r_nz[C_DIV_BITS+1];
    assign o_side = r_side[C_DIV_BITS+1];

endmodule

// File: hdl/esc_post.sv
// Pressure post-division correction and result word assembly.
module esc_post import esc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic signed [63:0] i_quo,
    input  logic               i_nz,
    input  t_side              i_side,
    input  t_calib             i_cal,
    output logic               o_vld,
    output t_out               o_res
);

    logic [5:1]         r_vld;
    logic signed [63:0] r_q [1:3];
    logic               r_nz [1:4];
    t_side              r_side [1:4];
    logic signed [63:0] r_m9, r_s13, r_p8q, r_v2, r_v2b, r_v1, r_sum;
    logic [63:0]        r_ll;
    logic [31:0]        r_hl, r_lh;
    t_out               r_res;

    logic signed [79:0] w_m9, w_p8q;
    logic [63:0]        w_ll, w_prod;
    logic [31:0]        w_hl, w_lh;
    logic signed [63:0] w_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:1], i_vld};
        end
    end

    assign w_m9   = i_cal.p9 * (i_quo >>> 13);
    assign w_p8q  = i_cal.p8 * i_quo;
    assign w_ll   = r_m9[31:0] * r_s13[31:0];
    assign w_hl   = r_m9[63:32] * r_s13[31:0];
    assign w_lh   = r_m9[31:0] * r_s13[63:32];
    assign w_prod = r_ll + {r_hl + r_lh, 32'b0};
    assign w_p    = (r_sum >>> 8) + (64'(i_cal.p7) <<< 4);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[1]    <= i_quo;
            r_nz[1]   <= i_nz;
            r_side[1] <= i_side;
            r_m9      <= w_m9[63:0];
            r_s13     <= i_quo >>> 13;
            r_p8q     <= w_p8q[63:0];
            r_ll      <= w_ll;
            r_hl      <= w_hl;
            r_lh      <= w_lh;
            r_v2      <= r_p8q >>> 19;
            r_v1      <= $signed(w_prod) >>> 25;
            r_v2b     <= r_v2;
            r_sum     <= r_q[3] + r_v1 + r_v2b;
            for (int k = 2; k <= 3; k++) begin
                r_q[k] <= r_q[k-1];
            end
            for (int k = 2; k <= 4; k++) begin
                r_nz[k]   <= r_nz[k-1];
                r_side[k] <= r_side[k-1];
            end
            r_res.temperature_centi <= r_side[4].temp;
            r_res.pressure_q24_8    <= r_nz[4] ? w_p[31:0] : '0;
            r_res.pressure_valid    <= r_nz[4];
            r_res.humidity_q22_10   <= r_side[4].hum;
        end
    end

    assign o_vld = r_vld[5];
    assign o_res = r_res;

endmodule

// File: hdl/env_sensor_compensation.sv
// Top level of the environmental sensor compensation pipeline.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------
//   input    | i_valid / o_ready         | i_data  (t_in, raw readings)
//   output   | o_valid / i_ready         | o_data  (t_out, results)
//   config   | i_cfg_wr_en               | i_cfg_index, i_cfg_wdata
//
// One word per cycle sustained while the output skid is not full.
// Depth is set by the 64 restoring steps of the pressure divider.
// i_rst_n is synchronous; it clears the valid bits, skid pointers and calibration.
// A 2-word output skid parts the pipeline from the consumer; a full skid
// freezes every stage at once, so no word is dropped or repeated.
`include "env_sensor_compensation_macros.svh"

module env_sensor_compensation import esc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_data,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata
);

    t_calib             w_cal;
    logic               w_adv;
    logic               w_fe_vld, w_dv_vld, w_po_vld;
    logic signed [63:0] w_num, w_den, w_quo;
    logic               w_nz;
    t_side              w_fe_side, w_dv_side;
    t_out               w_res;
    logic               w_push, w_pop;

    t_out               r_buf [0:1];
    logic               r_wp, r_rp;
    logic [1:0]         r_cnt;
    logic [1:0]         n_cnt;

    esc_calib u_calib (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cal       (w_cal)
    );

    esc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (i_valid),
        .i_data  (i_data),
        .i_cal   (w_cal),
        .o_vld   (w_fe_vld),
        .o_num   (w_num),
        .o_den   (w_den),
        .o_side  (w_fe_side)
    );

    esc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (w_fe_vld),
        .i_num   (w_num),
        .i_den   (w_den),
        .i_side  (w_fe_side),
        .o_vld   (w_dv_vld),
        .o_quo   (w_quo),
        .o_nz    (w_nz),
        .o_side  (w_dv_side)
    );

    esc_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (w_dv_vld),
        .i_quo   (w_quo),
        .i_nz    (w_nz),
        .i_side  (w_dv_side),
        .i_cal   (w_cal),
        .o_vld   (w_po_vld),
        .o_res   (w_res)
    );

    assign w_adv   = (r_cnt != 2'd2);
    assign o_ready = w_adv;
    assign w_push  = w_adv && w_po_vld;
    assign o_valid = (r_cnt != 2'd0);
    assign w_pop   = o_valid && i_ready;
    assign o_data  = r_buf[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push && w_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= w_res;
        end
    end

    `ESC_ASSERT_IMPL(a_skid_bound, 1'b1, r_cnt != 2'd3)
    `ESC_ASSERT_IMPL(a_no_push_full, r_cnt == 2'd2, !w_push)
    `ESC_ASSERT_NEXT(a_cnt_hold, !w_push && !w_pop, r_cnt == $past(r_cnt))
    `ESC_ASSERT_IMPL(a_pres_zero, o_valid && !o_data.pressure_valid, o_data.pressure_q24_8 == 32'd0)
    `ESC_ASSERT_IMPL(a_hum_range, o_valid, o_data.humidity_q22_10 <= 17'd102400)

endmodule

// File: tb/sv/tb_env_sensor_compensation.sv
// Testbench for env_sensor_compensation: random and directed raw words checked by a predictor.
`timescale 1ns / 100ps

module tb_env_sensor_compensation;
    import esc_pkg::*;

    class comp_scoreboard;
        logic [63:0] calib_words [4];
        logic [7:0]  calib_tail;
        t_out        pending_results [$];
        int          error_count;

        function new();
            foreach (calib_words[k]) calib_words[k] = '0;
            calib_tail  = '0;
            error_count = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] value);
            if (idx <= 3'(CFG_CALIB_D)) calib_words[idx] = value;
            else if (idx == 3'(CFG_CALIB_LAST)) calib_tail = value[7:0];
        endfunction

        function logic [7:0] cal_byte(int i);
            if (i >= 32) return calib_tail;
            return calib_words[i / 8][(i % 8) * 8 +: 8];
        endfunction

        function int cal_u16(int o);
            int v;
            v = {16'd0, cal_byte(o + 1), cal_byte(o)};
            return v;
        endfunction

        function int cal_s16(int o);
            logic signed [15:0] w;
            int v;
            w = {cal_byte(o + 1), cal_byte(o)};
            v = w;
            return v;
        endfunction

        function int cal_s8(int o);
            logic signed [7:0] w;
            int v;
            w = cal_byte(o);
            v = w;
            return v;
        endfunction

        function t_out compensate(t_in d);
            int t1, t2, t3, h1, h2, h3, h4, h5, h6, adc_t, adc_h;
            int x, y, sq, tfine, temp, hv, a, b;
            longint p1, p2, p3, p4, p5, p6, p7, p8, p9, adc_p, v1, v2, p, num;
            t_out r;
            t1 = cal_u16(0); t2 = cal_s16(2); t3 = cal_s16(4);
            p1 = cal_u16(6); p2 = cal_s16(8); p3 = cal_s16(10); p4 = cal_s16(12);
            p5 = cal_s16(14); p6 = cal_s16(16); p7 = cal_s16(18); p8 = cal_s16(20);
            p9 = cal_s16(22);
            h1 = int'(cal_byte(25)); h2 = cal_s16(26); h3 = int'(cal_byte(28));
            h4 = cal_s8(29) * 16 + int'(cal_byte(30) & 8'h0f);
            h5 = cal_s8(31) * 16 + int'(cal_byte(30) >> 4);
            h6 = cal_s8(32);
            adc_t = int'(d.raw_temperature);
            adc_p = longint'(d.raw_pressure);
            adc_h = int'(d.raw_humidity);

            x = (adc_t >>> 3) - (t1 <<< 1);
            y = (adc_t >>> 4) - t1;
            sq = y * y;
            tfine = ((x * t2) >>> 11) + (((sq >>> 12) * t3) >>> 14);
            temp = (tfine * 5 + 128) >>> 8;
            r.temperature_centi = temp;

            v1 = longint'(tfine) - 64'sd128000;
            v2 = v1 * v1 * p6;
            v2 = v2 + ((v1 * p5) <<< 17);
            v2 = v2 + (p4 <<< 35);
            v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
            v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
            r.pressure_q24_8 = '0;
            r.pressure_valid = 1'b0;
            if (v1 != 0) begin
                p = 64'sd1048576 - adc_p;
                num = ((p <<< 31) - v2) * 64'sd3125;
                p = (v1 == -64'sd1) ? -num : num / v1;
                v1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
                v2 = (p8 * p) >>> 19;
                p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
                r.pressure_q24_8 = p[31:0];
                r.pressure_valid = 1'b1;
            end

            hv = tfine - 76800;
            a = (adc_h <<< 14) - (h4 <<< 20) - (h5 * hv);
            a = (a + 16384) >>> 15;
            b = (((hv * h6) >>> 10) * (((hv * h3) >>> 11) + 32768)) >>> 10;
            b = (((b + 2097152) * h2) + 8192) >>> 14;
            hv = a * b;
            hv = hv - (((((hv >>> 15) * (hv >>> 15)) >>> 7) * h1) >>> 4);
            if (hv < 0) hv = 0;
            if (hv > 419430400) hv = 419430400;
            hv = hv >>> 12;
            r.humidity_q22_10 = hv[16:0];
            return r;
        endfunction

        function void note_input(t_in d);
            pending_results.push_back(compensate(d));
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %0h expected %0h", what, got, want);
            error_count++;
        endtask

        task check_result(t_out got);
            t_out want;
            if (pending_results.size() == 0) begin
                report("unexpected word", 64'(got), 64'd0);
                return;
            end
            want = pending_results.pop_front();
            if (got.temperature_centi !== want.temperature_centi)
                report("temperature_centi", 64'(got.temperature_centi),
                       64'(want.temperature_centi));
            if (got.pressure_q24_8 !== want.pressure_q24_8)
                report("pressure_q24_8", 64'(got.pressure_q24_8), 64'(want.pressure_q24_8));
            if (got.pressure_valid !== want.pressure_valid)
                report("pressure_valid", 64'(got.pressure_valid), 64'(want.pressure_valid));
            if (got.humidity_q22_10 !== want.humidity_q22_10)
                report("humidity_q22_10", 64'(got.humidity_q22_10),
                       64'(want.humidity_q22_10));
        endtask
    endclass

    localparam int PIPE_DRAIN = 120;
    localparam int STALL_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in         i_data;
    logic        o_valid;
    logic        i_ready;
    t_out        o_data;
    logic        i_cfg_wr_en;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_wdata;

    comp_scoreboard sb;
    bit          steady;
    int          quiet_cycles = 0;
    logic [7:0]  calib_set [33];

    env_sensor_compensation DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= steady || ($urandom_range(99) >= 14);
            if (o_valid && i_ready) sb.check_result(o_data);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_env_sensor_compensation failed");
            $finish;
        end
    end

    task send_word(t_in d);
        while (!steady && $urandom_range(99) < 14) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= d;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(d);
    endtask

    task wait_drained();
        i_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    task write_reg(logic [2:0] idx, logic [63:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.set_reg(idx, value);
    endtask

    task load_calibration();
        logic [63:0] w;
        for (int r = 0; r < 4; r++) begin
            for (int k = 0; k < 8; k++) w[k * 8 +: 8] = calib_set[r * 8 + k];
            write_reg(3'(CFG_CALIB_A) + 3'(r), w);
        end
        write_reg(CFG_CALIB_LAST, {$urandom, $urandom_range(255, 0) << 8}
                                  | 64'(calib_set[32]));
        write_reg(3'(CFG_CALIB_LAST) + 3'($urandom_range(3, 1)), {$urandom, $urandom});
        i_cfg_wr_en <= 1'b0;
    endtask

    task put16(int o, int v);
        calib_set[o]     = v[7:0];
        calib_set[o + 1] = v[15:8];
    endtask

    task typical_calibration();
        put16(0, 27504); put16(2, 26435); put16(4, -1000); put16(6, 36477);
        put16(8, -10685); put16(10, 3024); put16(12, 2855); put16(14, 140);
        put16(16, -7); put16(18, 15500); put16(20, -14600); put16(22, 6000);
        calib_set[24] = 8'h00; calib_set[25] = 8'd75; put16(26, 362);
        calib_set[28] = 8'd0; calib_set[29] = 8'd19; calib_set[30] = 8'h29;
        calib_set[31] = 8'd3; calib_set[32] = 8'd30;
    endtask

    task send_raw(int t, int p, int h);
        t_in d;
        d.raw_temperature = t[19:0];
        d.raw_pressure    = p[19:0];
        d.raw_humidity    = h[15:0];
        send_word(d);
    endtask

    task send_directed();
        send_raw(0, 0, 0);
        send_raw(20'hfffff, 20'hfffff, 16'hffff);
        send_raw(20'hfffff, 0, 16'hffff);
        send_raw(0, 20'hfffff, 0);
        send_raw(20'h55555, 20'haaaaa, 16'h5555);
        send_raw(20'haaaaa, 20'h55555, 16'haaaa);
        send_raw(519888, 415148, 30000);
        send_raw(400000, 250000, 0);
    endtask

    task send_random(int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 70)
                send_raw($urandom_range(600000, 400000), $urandom_range(450000, 250000),
                         $urandom_range(45000, 15000));
            else
                send_raw($urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        sb = new();
        steady = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_directed();
        wait_drained();

        typical_calibration();
        load_calibration();
        send_directed();
        send_random(200);
        wait_drained();

        steady = 1'b1;
        send_random(150);
        steady = 1'b0;
        send_random(50);
        wait_drained();

        foreach (calib_set[k]) calib_set[k] = 8'hff;
        load_calibration();
        send_directed();
        send_random(60);
        wait_drained();

        typical_calibration();
        put16(6, 0);
        load_calibration();
        send_random(60);
        wait_drained();

        for (int s = 0; s < 6; s++) begin
            if (s % 2 == 0) begin
                typical_calibration();
                for (int k = 0; k < 6; k++) calib_set[$urandom_range(32)] = 8'($urandom);
            end else begin
                foreach (calib_set[k]) calib_set[k] = 8'($urandom);
            end
            load_calibration();
            send_random(100);
            wait_drained();
        end

        foreach (calib_set[k]) calib_set[k] = 8'h00;
        load_calibration();
        send_random(30);
        wait_drained();

        if (sb.error_count == 0) $display("tb_env_sensor_compensation passed");
        else $display("tb_env_sensor_compensation failed");
        $finish;
    end
endmodule
